// ----- rtl/core/dia_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dia_pkg
// Types and codes shared by the descriptor id allocator modules.
// ---------------------------------------------------------------------------
package dia_pkg;

    localparam int LIMIT_BITS = 9;
    localparam logic [LIMIT_BITS-1:0] ID_LIMIT_RESET = 9'd256;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP  = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  id;
        logic [31:0] node_handle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  id_out;
        logic [31:0] handle_out;
    } out_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_RELEASE,
        S_LOOKUP
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic search_step;
        logic finish_alloc;
        logic finish_release;
        logic finish_lookup;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic search_done;
        logic out_free;
    } ctrl_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/dia_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dia_ctrl
// Sequencer: clearing pass after reset, request capture, map search and
// result commit.
// ---------------------------------------------------------------------------
module dia_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [1:0]         req_mode,
    input  wire dia_pkg::ctrl_sts_t sts,
    output logic                    in_stall,
    output dia_pkg::ctrl_cmd_t      cmd
);
    import dia_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_mode)
                        MODE_ALLOC:   state_next = S_ALLOC;
                        MODE_RELEASE: state_next = S_RELEASE;
                        default:      state_next = S_LOOKUP;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (sts.search_done && sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RELEASE, S_LOOKUP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_ALLOC:
            begin
                cmd.search_step  = !sts.search_done;
                cmd.finish_alloc = sts.search_done && sts.out_free;
            end
            S_RELEASE:
            begin
                cmd.finish_release = sts.out_free;
            end
            S_LOOKUP:
            begin
                cmd.finish_lookup = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/dia_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dia_datapath
// Free map and handle table memories, request registers, lowest-free
// word search, limit register and result register.
// ---------------------------------------------------------------------------
module dia_datapath #(
    parameter int MAX_IDS     = 256,
    parameter int WORD_BITS   = 32,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dia_pkg::in_item_t     in_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [8:0]            cfg_wr_data,
    input  wire dia_pkg::ctrl_cmd_t    cmd,
    output dia_pkg::ctrl_sts_t         sts,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output dia_pkg::out_item_t         out_data
);
    import dia_pkg::*;

    localparam int MAP_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int ID_W      = $clog2(MAX_IDS);
    localparam int CW        = $clog2(MAP_WORDS * WORD_BITS + 512);
    localparam int LAST_BITS = MAX_IDS - (MAP_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] ALL_FREE  = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_FREE = ALL_FREE >> (WORD_BITS - LAST_BITS);
    localparam int RECIP_SH  = 16;
    localparam int RECIP     = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);

    logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
    logic [HANDLE_BITS-1:0] handle_mem [MAX_IDS];

    logic [WORD_BITS-1:0]   map_rd_reg;
    logic [HANDLE_BITS-1:0] handle_rd_reg;

    logic [8:0]             id_limit_reg;
    logic [WADDR_W-1:0]     clr_cnt_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic [1:0]             req_mode_reg;
    logic [7:0]             req_id_reg;
    logic [HANDLE_BITS-1:0] req_handle_reg;
    logic [8:0]             req_q_reg;
    logic [WADDR_W-1:0]     word_cnt_reg;
    logic [CW-1:0]          base_reg;

    logic [24:0]            q_prod;
    logic [8:0]             q_next;
    logic [15:0]            q_mul;
    logic [15:0]            rem;
    logic [BIT_W-1:0]       bit_pos;
    logic [WORD_BITS-1:0]   bit_mask;

    logic [CW-1:0]          lim_ext;
    logic [CW-1:0]          eff_lim;
    logic [CW-1:0]          id_ext;
    logic                   id_ok;

    logic [WORD_BITS-1:0]   low_onehot;
    logic [BIT_W-1:0]       low_idx;
    logic                   word_nz;
    logic [CW-1:0]          cand_id;
    logic                   alloc_hit;
    logic                   more_words;
    logic                   lookup_ok;

    logic                   rd_en;
    logic [WADDR_W-1:0]     rd_addr;
    logic                   map_we;
    logic [WADDR_W-1:0]     map_waddr;
    logic [WORD_BITS-1:0]   map_wdata;
    logic                   load_out;
    out_item_t              result;

    // request word index: id / WORD_BITS by reciprocal, exact for 8-bit ids
    assign q_prod  = 25'(in_data.id) * 25'(RECIP);
    assign q_next  = q_prod[24:16];
    assign q_mul   = 16'(req_q_reg) * 16'(WORD_BITS);
    assign rem     = 16'(req_id_reg) - q_mul;
    assign bit_pos = BIT_W'(rem);
    assign bit_mask = WORD_BITS'(1) << bit_pos;

    assign lim_ext = CW'(id_limit_reg);
    assign eff_lim = (lim_ext > CW'(MAX_IDS)) ? CW'(MAX_IDS) : lim_ext;
    assign id_ext  = CW'(req_id_reg);
    assign id_ok   = id_ext < eff_lim;

    assign low_onehot = map_rd_reg & (~map_rd_reg + WORD_BITS'(1));
    assign word_nz    = |map_rd_reg;

    always_comb
    begin
        low_idx = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (low_onehot[b])
            begin
                low_idx = low_idx | BIT_W'(b);
            end
        end
    end

    assign cand_id    = base_reg + CW'(low_idx);
    assign alloc_hit  = word_nz && (cand_id < eff_lim);
    assign more_words = (base_reg + CW'(WORD_BITS)) < eff_lim;
    assign lookup_ok  = (req_mode_reg == MODE_LOOKUP) && id_ok && !map_rd_reg[bit_pos];

    assign sts.clear_last  = (clr_cnt_reg == LAST_WORD);
    assign sts.search_done = word_nz || !more_words;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.capture)
        begin
            rd_en = 1'b1;
            if (in_data.mode != MODE_ALLOC)
            begin
                rd_addr = WADDR_W'(q_next);
            end
        end
        else if (cmd.search_step)
        begin
            rd_en   = 1'b1;
            rd_addr = word_cnt_reg + WADDR_W'(1);
        end
    end

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = word_cnt_reg;
        map_wdata = map_rd_reg & ~low_onehot;
        if (cmd.clear_step)
        begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_reg;
            map_wdata = (clr_cnt_reg == LAST_WORD) ? LAST_FREE : ALL_FREE;
        end
        else if (cmd.finish_alloc)
        begin
            map_we = alloc_hit;
        end
        else if (cmd.finish_release)
        begin
            map_we    = id_ok;
            map_waddr = WADDR_W'(req_q_reg);
            map_wdata = map_rd_reg | bit_mask;
        end
    end

    always_comb
    begin
        load_out          = cmd.finish_alloc || cmd.finish_release || cmd.finish_lookup;
        result.status     = STAT_BAD;
        result.id_out     = req_id_reg;
        result.handle_out = '0;
        if (cmd.finish_alloc)
        begin
            if (alloc_hit)
            begin
                result.status = STAT_OK;
                result.id_out = 8'(cand_id);
            end
            else
            begin
                result.status = STAT_FULL;
            end
        end
        else if (cmd.finish_release)
        begin
            result.status = id_ok ? STAT_OK : STAT_BAD;
        end
        else if (lookup_ok)
        begin
            result.status     = STAT_OK;
            result.handle_out = 32'(handle_rd_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (rd_en)
        begin
            map_rd_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_alloc && alloc_hit)
        begin
            handle_mem[ID_W'(cand_id)] <= req_handle_reg;
        end
        if (cmd.capture)
        begin
            handle_rd_reg <= handle_mem[ID_W'(in_data.id)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_mode_reg   <= in_data.mode;
            req_id_reg     <= in_data.id;
            req_handle_reg <= HANDLE_BITS'(in_data.node_handle);
            req_q_reg      <= q_next;
            word_cnt_reg   <= '0;
            base_reg       <= '0;
        end
        else if (cmd.search_step)
        begin
            word_cnt_reg <= word_cnt_reg + WADDR_W'(1);
            base_reg     <= base_reg + CW'(WORD_BITS);
        end
        if (load_out)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_limit_reg  <= ID_LIMIT_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                id_limit_reg <= cfg_wr_data;
            end
            if (cmd.clear_step && (clr_cnt_reg != LAST_WORD))
            begin
                clr_cnt_reg <= clr_cnt_reg + WADDR_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/descriptor_id_allocator.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// descriptor_id_allocator
// Lowest-free bitmap allocator for descriptor ids with a stored handle per id.
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     in_data     (in_item_t)
//  out       output     out_valid / out_stall   out_data    (out_item_t)
//  cfg       input      cfg_wr_en               cfg_wr_data (id_limit)
//
//  Release and lookup do a transfer, then one free map word read.
//  Allocate reads map word 0 at transfer, then scans further map words, one per cycle.
//  After reset the free map is cleared, one word a cycle, all MAP_WORDS words
//  (8 at the defaults), with in_stall high.
//  Results go to an output register; a request waits at commit while it is held.
// ---------------------------------------------------------------------------
module descriptor_id_allocator #(
    parameter int MAX_IDS     = 256,
    parameter int WORD_BITS   = 32,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire dia_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output dia_pkg::out_item_t     out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [8:0]        cfg_wr_data
);
    import dia_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    dia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_mode (in_data.mode),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    dia_datapath #(
        .MAX_IDS     (MAX_IDS),
        .WORD_BITS   (WORD_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for descriptor_id_allocator. A directed script covers
// reset state, id extremes, table full, bad ids and limit changes, followed by
// random phases at several id limits. Replies are checked against typed rows or
// a free-map and handle-table shadow model. Both channels idle at random.
// ---------------------------------------------------------------------------
module testbench;
    import dia_pkg::*;

    localparam int MAX_IDS = 256;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PCT = 21;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_AT = 150;
    localparam int PAUSE_AT = 420;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO = 720;
    localparam int TAIL_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic        cfg_write;
        logic [8:0]  limit;
        in_item_t    req;
        logic        typed;
        out_item_t   want;
    } script_row_t;

    typedef struct packed {
        logic        typed;
        out_item_t   want;
    } request_note_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [8:0]  cfg_wr_data = '0;

    bit          id_free [MAX_IDS] = '{default: 1'b1};
    logic [31:0] stored_handle [MAX_IDS];
    logic [8:0]  limit_shadow = ID_LIMIT_RESET;

    request_note_t request_notes [$];
    out_item_t     pending_replies [$];
    int            error_count = 0;
    int            random_sent = 0;
    int unsigned   cycle_count = 0;
    bit            calm = 1'b0;
    bit            hold_off_req = 1'b0;

    descriptor_id_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic out_item_t compute_reply(input in_item_t req);
        out_item_t   reply;
        int unsigned lim;
        lim = (limit_shadow > MAX_IDS) ? MAX_IDS : limit_shadow;
        reply.status = STAT_BAD;
        reply.id_out = req.id;
        reply.handle_out = '0;
        case (req.mode)
            MODE_ALLOC:
            begin
                reply.status = STAT_FULL;
                for (int n = 0; n < lim; n++)
                begin
                    if (id_free[n])
                    begin
                        id_free[n] = 1'b0;
                        stored_handle[n] = req.node_handle;
                        reply.status = STAT_OK;
                        reply.id_out = 8'(n);
                        break;
                    end
                end
            end
            MODE_RELEASE:
            begin
                if (req.id < lim)
                begin
                    id_free[req.id] = 1'b1;
                    reply.status = STAT_OK;
                end
            end
            MODE_LOOKUP:
            begin
                if (req.id < lim && !id_free[req.id])
                begin
                    reply.status = STAT_OK;
                    reply.handle_out = stored_handle[req.id];
                end
            end
            default:
            begin
            end
        endcase
        return reply;
    endfunction

    // request side: cfg writes update the shadow limit, accepted transfers the shadow state
    always @(posedge clk)
    begin : request_monitor
        request_note_t note;
        out_item_t     reply;
        if (cfg_wr_en)
        begin
            limit_shadow = cfg_wr_data;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            note = request_notes.pop_front();
            reply = compute_reply(in_data);
            pending_replies.push_back(note.typed ? note.want : reply);
        end
    end

    always @(posedge clk)
    begin : reply_checker
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply: status %0d id_out %0d handle_out 0x%08h",
                       out_data.status, out_data.id_out, out_data.handle_out);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, out_data.status);
                    error_count++;
                end
                if (out_data.id_out !== want.id_out)
                begin
                    $error("id_out mismatch: expected %0d, got %0d",
                           want.id_out, out_data.id_out);
                    error_count++;
                end
                if (out_data.handle_out !== want.handle_out)
                begin
                    $error("handle_out mismatch: expected 0x%08h, got 0x%08h",
                           want.handle_out, out_data.handle_out);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : reply_receiver
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_request(input in_item_t req, input logic typed,
                                input out_item_t want);
        request_note_t note;
        note.typed = typed;
        note.want = want;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        request_notes.push_back(note);
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0 || request_notes.size() != 0) @(posedge clk);
    endtask

    task automatic write_id_limit(input logic [8:0] value);
        drain_replies();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly used ids below the limit, plus boundary and random ids
    function automatic logic [7:0] choose_target_id(input int unsigned lim);
        int unsigned roll;
        int unsigned start;
        int unsigned n;
        roll = $urandom_range(99);
        if (roll < 20)
        begin
            return 8'(lim - $urandom_range(1));
        end
        if (roll < 45 || lim == 0)
        begin
            return 8'($urandom);
        end
        start = $urandom_range(lim - 1);
        for (int k = 0; k < lim; k++)
        begin
            n = (start + k) % lim;
            if (!id_free[n])
            begin
                return 8'(n);
            end
        end
        return 8'(start);
    endfunction

    task automatic run_random_phase(input int items, input logic [8:0] limit,
                                    input int alloc_pct, input int release_pct);
        in_item_t    req;
        int unsigned lim;
        int unsigned roll;
        write_id_limit(limit);
        lim = (limit > MAX_IDS) ? MAX_IDS : limit;
        repeat (items)
        begin
            if (random_sent == HOLD_AT)
            begin
                hold_off_req = 1'b1;
            end
            if (random_sent == PAUSE_AT)
            begin
                drain_replies();
            end
            calm = (random_sent >= CALM_FROM && random_sent < CALM_TO);
            roll = $urandom_range(99);
            req.id = 8'($urandom);
            req.node_handle = $urandom;
            if (roll < alloc_pct)
            begin
                req.mode = MODE_ALLOC;
            end
            else if (roll < alloc_pct + release_pct)
            begin
                req.mode = MODE_RELEASE;
            end
            else if (roll < 95)
            begin
                req.mode = MODE_LOOKUP;
            end
            else
            begin
                req.mode = MODE_UNUSED;
            end
            if (req.mode == MODE_RELEASE || req.mode == MODE_LOOKUP)
            begin
                req.id = choose_target_id(lim);
            end
            send_request(req, 1'b0, '0);
            random_sent++;
        end
        calm = 1'b0;
    endtask

    function automatic script_row_t cfg_row(input logic [8:0] limit);
        script_row_t row;
        row = '0;
        row.cfg_write = 1'b1;
        row.limit = limit;
        return row;
    endfunction

    function automatic script_row_t req_row(input logic [1:0] mode, input logic [7:0] id,
                                            input logic [31:0] handle);
        script_row_t row;
        row = '0;
        row.req.mode = mode;
        row.req.id = id;
        row.req.node_handle = handle;
        return row;
    endfunction

    function automatic script_row_t typed_row(input logic [1:0] mode, input logic [7:0] id,
                                              input logic [31:0] handle,
                                              input logic [1:0] status,
                                              input logic [7:0] id_out,
                                              input logic [31:0] handle_out);
        script_row_t row;
        row = req_row(mode, id, handle);
        row.typed = 1'b1;
        row.want.status = status;
        row.want.id_out = id_out;
        row.want.handle_out = handle_out;
        return row;
    endfunction

    initial
    begin : stimulus
        script_row_t directed_script [29];
        directed_script = '{
            typed_row(MODE_LOOKUP, 8'd0, 32'h0, STAT_BAD, 8'd0, 32'h0),
            typed_row(MODE_RELEASE, 8'd255, 32'h0, STAT_OK, 8'd255, 32'h0),
            typed_row(MODE_UNUSED, 8'hAA, 32'hFFFF_FFFF, STAT_BAD, 8'hAA, 32'h0),
            typed_row(MODE_ALLOC, 8'h55, 32'hFFFF_FFFF, STAT_OK, 8'd0, 32'h0),
            typed_row(MODE_ALLOC, 8'd0, 32'h0, STAT_OK, 8'd1, 32'h0),
            typed_row(MODE_LOOKUP, 8'd0, 32'h0, STAT_OK, 8'd0, 32'hFFFF_FFFF),
            typed_row(MODE_LOOKUP, 8'd1, 32'hFFFF_FFFF, STAT_OK, 8'd1, 32'h0),
            typed_row(MODE_RELEASE, 8'd0, 32'h0, STAT_OK, 8'd0, 32'h0),
            typed_row(MODE_LOOKUP, 8'd0, 32'h0, STAT_BAD, 8'd0, 32'h0),
            typed_row(MODE_ALLOC, 8'hFF, 32'h1234_5678, STAT_OK, 8'd0, 32'h0),
            typed_row(MODE_ALLOC, 8'd0, 32'hA5A5_5A5A, STAT_OK, 8'd2, 32'h0),
            typed_row(MODE_LOOKUP, 8'd255, 32'h0, STAT_BAD, 8'd255, 32'h0),
            cfg_row(9'd2),
            typed_row(MODE_ALLOC, 8'hFF, 32'h0BAD_F00D, STAT_FULL, 8'hFF, 32'h0),
            typed_row(MODE_RELEASE, 8'd2, 32'h0, STAT_BAD, 8'd2, 32'h0),
            typed_row(MODE_LOOKUP, 8'd1, 32'h0, STAT_OK, 8'd1, 32'h0),
            cfg_row(9'd0),
            typed_row(MODE_ALLOC, 8'd7, 32'h0, STAT_FULL, 8'd7, 32'h0),
            typed_row(MODE_RELEASE, 8'd0, 32'h0, STAT_BAD, 8'd0, 32'h0),
            typed_row(MODE_LOOKUP, 8'd0, 32'h0, STAT_BAD, 8'd0, 32'h0),
            cfg_row(9'd511),
            typed_row(MODE_LOOKUP, 8'd2, 32'h0, STAT_OK, 8'd2, 32'hA5A5_5A5A),
            typed_row(MODE_LOOKUP, 8'd0, 32'h0, STAT_OK, 8'd0, 32'h1234_5678),
            cfg_row(9'd1),
            req_row(MODE_RELEASE, 8'd0, 32'h0),
            req_row(MODE_ALLOC, 8'h80, 32'h0F0F_F0F0),
            req_row(MODE_ALLOC, 8'h3C, 32'h8000_0001),
            cfg_row(9'd256),
            req_row(MODE_LOOKUP, 8'd0, 32'h0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_script[i])
        begin
            if (directed_script[i].cfg_write)
            begin
                write_id_limit(directed_script[i].limit);
            end
            else
            begin
                send_request(directed_script[i].req, directed_script[i].typed,
                             directed_script[i].want);
            end
        end

        run_random_phase(300, 9'd256, 92, 2);
        run_random_phase(70, 9'd256, 20, 45);
        run_random_phase(70, 9'd1, 35, 30);
        run_random_phase(40, 9'd0, 35, 30);
        run_random_phase(70, 9'd511, 35, 30);
        run_random_phase(70, 9'd2, 40, 25);
        run_random_phase(80, 9'd8, 40, 25);
        run_random_phase(80, 9'd255, 35, 30);
        run_random_phase(70, 9'd257, 30, 35);
        run_random_phase(60, 9'($urandom_range(64, 1)), 40, 25);
        run_random_phase(60, 9'($urandom_range(256, 1)), 35, 30);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d replies never arrived", pending_replies.size());
            error_count++;
        end

        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
